### rtl/srcp_pkg.sv
// ----------------------------------------------------------------------------
// srcp_pkg
// Shared types, codes and the silence table of the sound register command
// player.
// ----------------------------------------------------------------------------
package srcp_pkg;

   // default width of the stream offset counter
   localparam int OFFSET_BITS_DEFAULT = 24;

   // silence sequence length and its index width
   localparam int SILENCE_LEN  = 36;
   localparam int SIL_IDX_BITS = 6;

   // reset values of the configuration registers
   localparam logic [31:0] STREAM_BASE_RESET  = 32'h0000_0000;
   localparam logic [7:0]  WRITE_OPCODE_RESET = 8'h01;
   localparam logic [7:0]  WAIT_OPCODE_RESET  = 8'h02;
   localparam logic [7:0]  END_OPCODE_RESET   = 8'h03;

   // request codes
   typedef enum logic [1:0] {
      REQ_PLAY = 2'd0,
      REQ_STOP = 2'd1,
      REQ_TICK = 2'd2,
      REQ_BYTE = 2'd3
   } req_code_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_WRITE   = 3'd0,
      KIND_FETCH   = 3'd1,
      KIND_FRAME   = 3'd2,
      KIND_STOPPED = 3'd3,
      KIND_UNKNOWN = 3'd4
   } kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_STREAM_BASE  = 2'd0,
      CSR_WRITE_OPCODE = 2'd1,
      CSR_WAIT_OPCODE  = 2'd2,
      CSR_END_OPCODE   = 2'd3
   } csr_index_type;

   // command parser phase
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_CMD   = 3'd1,
      PH_ADDR  = 3'd2,
      PH_DATA  = 3'd3,
      PH_LOOP0 = 3'd4,
      PH_LOOP1 = 3'd5,
      PH_LOOP2 = 3'd6,
      PH_LOOP3 = 3'd7
   } phase_type;

   // closing result of a request
   typedef enum logic [2:0] {
      TAIL_NONE    = 3'd0,
      TAIL_FETCH   = 3'd1,
      TAIL_FRAME   = 3'd2,
      TAIL_STOPPED = 3'd3,
      TAIL_UNKNOWN = 3'd4
   } tail_type;

   // configuration register set
   typedef struct packed {
      logic [31:0] stream_base;
      logic [7:0]  write_opcode;
      logic [7:0]  wait_opcode;
      logic [7:0]  end_opcode;
   } cfg_type;

   // result job handed from parser to emitter: silence, then write, then tail
   typedef struct packed {
      logic        sil;
      logic        wr;
      logic [7:0]  waddr;
      logic [7:0]  wdata;
      tail_type    tail;
      logic [23:0] play_offset;
      logic [31:0] fetch_address;
   } job_type;

   // silence sequence register offsets
   function automatic logic [7:0] silence_addr(input logic [SIL_IDX_BITS-1:0] idx);
      logic [7:0] a;
      case (idx)
         6'd0:    a = 8'h84;
         6'd1:    a = 8'h60;
         6'd2:    a = 8'h62;
         6'd3:    a = 8'h63;
         6'd4:    a = 8'h64;
         6'd5:    a = 8'h65;
         6'd6:    a = 8'h68;
         6'd7:    a = 8'h69;
         6'd8:    a = 8'h6c;
         6'd9:    a = 8'h6d;
         6'd10:   a = 8'h90;
         6'd11:   a = 8'h91;
         6'd12:   a = 8'h92;
         6'd13:   a = 8'h93;
         6'd14:   a = 8'h94;
         6'd15:   a = 8'h95;
         6'd16:   a = 8'h96;
         6'd17:   a = 8'h97;
         6'd18:   a = 8'h98;
         6'd19:   a = 8'h99;
         6'd20:   a = 8'h9a;
         6'd21:   a = 8'h9b;
         6'd22:   a = 8'h9c;
         6'd23:   a = 8'h9d;
         6'd24:   a = 8'h9e;
         6'd25:   a = 8'h9f;
         6'd26:   a = 8'h70;
         6'd27:   a = 8'h72;
         6'd28:   a = 8'h74;
         6'd29:   a = 8'h78;
         6'd30:   a = 8'h79;
         6'd31:   a = 8'h7c;
         6'd32:   a = 8'h7d;
         6'd33:   a = 8'h80;
         6'd34:   a = 8'h81;
         6'd35:   a = 8'h84;
         default: a = 8'h00;
      endcase
      return a;
   endfunction

   // silence sequence data bytes
   function automatic logic [7:0] silence_data(input logic [SIL_IDX_BITS-1:0] idx);
      logic [7:0] d;
      case (idx)
         6'd28:   d = 8'h80;
         6'd33:   d = 8'h77;
         6'd34:   d = 8'hff;
         6'd35:   d = 8'h80;
         default: d = 8'h00;
      endcase
      return d;
   endfunction

endpackage

### rtl/srcp_parser.sv
// ----------------------------------------------------------------------------
// srcp_parser
// Player state and command decode: updates the play state on each accepted
// request and builds the result job for it.
// ----------------------------------------------------------------------------
module srcp_parser #(
   parameter int OFFSET_BITS = srcp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        req_type,
   input  logic              req_loop_enable,
   input  logic [7:0]        req_stream_byte,
   input  srcp_pkg::cfg_type cfg,
   output srcp_pkg::job_type job
);
   import srcp_pkg::*;

   // play state
   logic                   playing_ff, playing_in;
   logic                   loop_flag_ff, loop_flag_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   phase_type              phase_ff, phase_in;
   logic [7:0]             held_addr_ff, held_addr_in;
   logic [31:0]            accum_ff, accum_in;

   // command byte decode, write tested first, then wait, then end
   logic         is_write, is_wait, is_end, active;
   req_code_type req;
   logic [31:0]  byte_lane;
   logic [1:0]   lane_sel;

   assign req      = req_code_type'(req_type);
   assign active   = playing_ff && (phase_ff != PH_IDLE);
   assign is_write = (req_stream_byte == cfg.write_opcode);
   assign is_wait  = !is_write && (req_stream_byte == cfg.wait_opcode);
   assign is_end   = !is_write && !is_wait && (req_stream_byte == cfg.end_opcode);
   assign lane_sel = phase_ff[1:0];
   assign byte_lane = 32'(req_stream_byte) << {lane_sel, 3'b000};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (req)
         REQ_PLAY: phase_in = PH_IDLE;
         REQ_STOP: phase_in = PH_IDLE;
         REQ_TICK: begin
            if (playing_ff && phase_ff == PH_IDLE) phase_in = PH_CMD;
         end
         REQ_BYTE: begin
            if (active) begin
               unique case (phase_ff)
                  PH_CMD: begin
                     if (is_write) phase_in = PH_ADDR;
                     else if (is_end && loop_flag_ff) phase_in = PH_LOOP0;
                     else phase_in = PH_IDLE;
                  end
                  PH_ADDR:  phase_in = PH_DATA;
                  PH_DATA:  phase_in = PH_CMD;
                  PH_LOOP0: phase_in = PH_LOOP1;
                  PH_LOOP1: phase_in = PH_LOOP2;
                  PH_LOOP2: phase_in = PH_LOOP3;
                  PH_LOOP3: phase_in = PH_IDLE;
                  default:  phase_in = PH_IDLE;
               endcase
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   // state updates and result job
   always_comb begin
      playing_in   = playing_ff;
      loop_flag_in = loop_flag_ff;
      offset_in    = offset_ff;
      held_addr_in = held_addr_ff;
      accum_in     = accum_ff;

      job               = '0;
      job.tail          = TAIL_NONE;
      job.play_offset   = 24'(offset_ff);
      job.fetch_address = cfg.stream_base + 32'(offset_ff);

      unique case (req)
         REQ_PLAY: begin
            playing_in      = 1'b1;
            loop_flag_in    = req_loop_enable;
            offset_in       = '0;
            held_addr_in    = '0;
            accum_in        = '0;
            job.sil         = 1'b1;
            job.play_offset = '0;
         end
         REQ_STOP: begin
            playing_in = 1'b0;
            job.sil    = 1'b1;
            job.tail   = TAIL_STOPPED;
         end
         REQ_TICK: begin
            if (!playing_ff) begin
               job.tail = TAIL_STOPPED;
            end else if (phase_ff == PH_IDLE) begin
               job.tail  = TAIL_FETCH;
               offset_in = offset_ff + 1'b1;
            end
         end
         REQ_BYTE: begin
            if (active) begin
               unique case (phase_ff)
                  PH_CMD: begin
                     if (is_write) begin
                        job.tail  = TAIL_FETCH;
                        offset_in = offset_ff + 1'b1;
                     end else if (is_wait) begin
                        job.tail = TAIL_FRAME;
                     end else if (is_end && loop_flag_ff) begin
                        accum_in  = '0;
                        job.tail  = TAIL_FETCH;
                        offset_in = offset_ff + 1'b1;
                     end else if (is_end) begin
                        playing_in = 1'b0;
                        job.sil    = 1'b1;
                        job.tail   = TAIL_STOPPED;
                     end else begin
                        job.tail = TAIL_UNKNOWN;
                     end
                  end
                  PH_ADDR: begin
                     held_addr_in = req_stream_byte;
                     job.tail     = TAIL_FETCH;
                     offset_in    = offset_ff + 1'b1;
                  end
                  PH_DATA: begin
                     job.wr    = 1'b1;
                     job.waddr = held_addr_ff;
                     job.wdata = req_stream_byte;
                     job.tail  = TAIL_FETCH;
                     offset_in = offset_ff + 1'b1;
                  end
                  PH_LOOP3: begin
                     // frame done reports the offset after the jump
                     accum_in        = accum_ff | byte_lane;
                     offset_in       = OFFSET_BITS'(accum_ff | byte_lane);
                     job.play_offset = 24'(offset_in);
                     job.tail        = TAIL_FRAME;
                  end
                  default: begin
                     // first three loop offset bytes
                     accum_in  = accum_ff | byte_lane;
                     job.tail  = TAIL_FETCH;
                     offset_in = offset_ff + 1'b1;
                  end
               endcase
            end
         end
         default: job.tail = TAIL_NONE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         playing_ff   <= 1'b0;
         loop_flag_ff <= 1'b0;
         offset_ff    <= '0;
         phase_ff     <= PH_IDLE;
         held_addr_ff <= '0;
         accum_ff     <= '0;
      end else if (accept) begin
         playing_ff   <= playing_in;
         loop_flag_ff <= loop_flag_in;
         offset_ff    <= offset_in;
         phase_ff     <= phase_in;
         held_addr_ff <= held_addr_in;
         accum_ff     <= accum_in;
      end
   end

endmodule

### rtl/srcp_emitter.sv
// ----------------------------------------------------------------------------
// srcp_emitter
// Result register: holds the job of one request and hands its results out
// one per cycle while rsp_ready is up: silence writes, a write, then the tail.
// ----------------------------------------------------------------------------
module srcp_emitter (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  srcp_pkg::job_type job,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_kind,
   output logic [7:0]        rsp_reg_addr,
   output logic [7:0]        rsp_reg_data,
   output logic [31:0]       rsp_fetch_address,
   output logic [23:0]       rsp_play_offset,
   output logic              rsp_last
);
   import srcp_pkg::*;

   localparam logic [SIL_IDX_BITS-1:0] SIL_LAST = SIL_IDX_BITS'(SILENCE_LEN - 1);

   // job registers
   logic                    sil_ff;
   logic [SIL_IDX_BITS-1:0] idx_ff;
   logic                    wr_ff;
   logic [7:0]              waddr_ff;
   logic [7:0]              wdata_ff;
   tail_type                tail_ff;
   logic [23:0]             poff_ff;
   logic [31:0]             faddr_ff;

   logic     take, tail_on;
   kind_type kind;

   assign tail_on   = (tail_ff != TAIL_NONE);
   assign rsp_valid = sil_ff || wr_ff || tail_on;
   assign take      = rsp_valid && rsp_ready;
   assign req_ready = !rsp_valid || (take && rsp_last);

   // current result
   always_comb begin
      kind              = KIND_WRITE;
      rsp_reg_addr      = '0;
      rsp_reg_data      = '0;
      rsp_fetch_address = '0;
      rsp_last          = 1'b1;
      if (sil_ff) begin
         rsp_reg_addr = silence_addr(idx_ff);
         rsp_reg_data = silence_data(idx_ff);
         rsp_last     = (idx_ff == SIL_LAST) && !wr_ff && !tail_on;
      end else if (wr_ff) begin
         rsp_reg_addr = waddr_ff;
         rsp_reg_data = wdata_ff;
         rsp_last     = !tail_on;
      end else begin
         case (tail_ff)
            TAIL_FETCH: begin
               kind              = KIND_FETCH;
               rsp_fetch_address = faddr_ff;
            end
            TAIL_FRAME:   kind = KIND_FRAME;
            TAIL_UNKNOWN: kind = KIND_UNKNOWN;
            default:      kind = KIND_STOPPED;
         endcase
      end
   end

   assign rsp_kind        = kind;
   assign rsp_play_offset = poff_ff;

   // job control: load on a new request, else step on each taken result
   always_ff @(posedge clock) begin
      if (reset) begin
         sil_ff  <= 1'b0;
         wr_ff   <= 1'b0;
         tail_ff <= TAIL_NONE;
         idx_ff  <= '0;
      end else if (accept) begin
         sil_ff  <= job.sil;
         wr_ff   <= job.wr;
         tail_ff <= job.tail;
         idx_ff  <= '0;
      end else if (take) begin
         if (sil_ff) begin
            if (idx_ff == SIL_LAST) sil_ff <= 1'b0;
            idx_ff <= idx_ff + 1'b1;
         end else if (wr_ff) begin
            wr_ff <= 1'b0;
         end else begin
            tail_ff <= TAIL_NONE;
         end
      end
   end

   // job payload
   always_ff @(posedge clock) begin
      if (accept) begin
         waddr_ff <= job.waddr;
         wdata_ff <= job.wdata;
         poff_ff  <= job.play_offset;
         faddr_ff <= job.fetch_address;
      end
   end

endmodule

### rtl/sound_register_command_player.sv
// ----------------------------------------------------------------------------
// sound_register_command_player
// Walks a music command stream one frame tick at a time and turns it into
// sound register writes and stream fetch requests.
// ----------------------------------------------------------------------------
// A request is decoded in the cycle it is accepted and its results are loaded
// into a single result register that hands out one result per cycle while
// rsp_ready is high. A request with one result (a tick, a fetched command,
// address or loop byte, an unknown command) is followed by the next request
// in the next cycle if its result is taken, so a stream byte can be parsed
// every cycle while rsp_ready is high. A register write's data byte yields
// two results. Play yields the silence sequence, stop and end of music without
// looping add a stopped result; new requests wait while these drain. Offsets
// wrap at OFFSET_BITS bits and fetch addresses at 32 bits.
// ----------------------------------------------------------------------------
module sound_register_command_player #(
   parameter int OFFSET_BITS = srcp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic        req_loop_enable,
   input  logic [7:0]  req_stream_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_reg_addr,
   output logic [7:0]  rsp_reg_data,
   output logic [31:0] rsp_fetch_address,
   output logic [23:0] rsp_play_offset,
   output logic        rsp_last,
   // configuration port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import srcp_pkg::*;

   cfg_type cfg_ff;
   job_type job;
   logic    accept;

   assign accept = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stream_base  <= STREAM_BASE_RESET;
         cfg_ff.write_opcode <= WRITE_OPCODE_RESET;
         cfg_ff.wait_opcode  <= WAIT_OPCODE_RESET;
         cfg_ff.end_opcode   <= END_OPCODE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_STREAM_BASE:  cfg_ff.stream_base  <= csr_wdata;
            CSR_WRITE_OPCODE: cfg_ff.write_opcode <= csr_wdata[7:0];
            CSR_WAIT_OPCODE:  cfg_ff.wait_opcode  <= csr_wdata[7:0];
            CSR_END_OPCODE:   cfg_ff.end_opcode   <= csr_wdata[7:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   // command decode and play state
   srcp_parser #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_type        (req_type),
      .req_loop_enable (req_loop_enable),
      .req_stream_byte (req_stream_byte),
      .cfg             (cfg_ff),
      .job             (job)
   );

   // result register
   srcp_emitter u_emitter (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .job               (job),
      .req_ready         (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_reg_addr      (rsp_reg_addr),
      .rsp_reg_data      (rsp_reg_data),
      .rsp_fetch_address (rsp_fetch_address),
      .rsp_play_offset   (rsp_play_offset),
      .rsp_last          (rsp_last)
   );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sound register command player. Play, stop,
// tick and stream byte requests go in over a valid/ready channel with random
// gaps. A model of the player in this file predicts every result, and each
// result is compared field by field as it leaves the block under random
// back-pressure. Directed frames come first, then mostly well-formed random
// command streams under several opcode and base address settings.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srcp_pkg::*;

   localparam int OFFSET_BITS    = OFFSET_BITS_DEFAULT;
   // longest busy stretch is a silence run plus its stopped result
   localparam int SETTLE_CYCLES  = 48;
   localparam int WATCHDOG_LIMIT = 2000;

   // silence sequence, register offsets and values
   localparam logic [7:0] SILENCE_REG_OFFSET [SILENCE_LEN] = '{
      8'h84, 8'h60, 8'h62, 8'h63, 8'h64, 8'h65, 8'h68, 8'h69, 8'h6c, 8'h6d,
      8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
      8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'h9f,
      8'h70, 8'h72, 8'h74, 8'h78, 8'h79, 8'h7c, 8'h7d, 8'h80, 8'h81, 8'h84
   };
   localparam logic [7:0] SILENCE_REG_VALUE [SILENCE_LEN] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h77, 8'hff, 8'h80
   };

   typedef struct {
      kind_type    kind;
      logic [7:0]  reg_addr;
      logic [7:0]  reg_data;
      logic [31:0] fetch_address;
      logic [23:0] play_offset;
      logic        last;
   } player_output_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   // block ports
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type         = REQ_TICK;
   logic        req_loop_enable  = 1'b0;
   logic [7:0]  req_stream_byte  = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_reg_addr;
   logic [7:0]  rsp_reg_data;
   logic [31:0] rsp_fetch_address;
   logic [23:0] rsp_play_offset;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index        = CSR_STREAM_BASE;
   logic [31:0] csr_wdata        = 32'h0;

   sound_register_command_player u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_loop_enable   (req_loop_enable),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_reg_addr      (rsp_reg_addr),
      .rsp_reg_data      (rsp_reg_data),
      .rsp_fetch_address (rsp_fetch_address),
      .rsp_play_offset   (rsp_play_offset),
      .rsp_last          (rsp_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // player model state
   cfg_type                player_cfg;
   logic                   playing_q;
   logic                   looping_q;
   logic [OFFSET_BITS-1:0] offset_q;
   phase_type              phase_q;
   logic [7:0]             held_addr_q;
   logic [31:0]            loop_offset_q;

   player_output_type player_output_q [$];
   int                outputs_this_request;
   int                mismatch_count = 0;
   int                idle_cycles    = 0;
   bit                src_gaps_on    = 1'b1;
   bit                sink_stalls_on = 1'b1;

   // ---------------------------------------------------------------- model

   function automatic void clear_player();
      playing_q     = 1'b0;
      looping_q     = 1'b0;
      offset_q      = '0;
      phase_q       = PH_IDLE;
      held_addr_q   = 8'h00;
      loop_offset_q = 32'h0;
   endfunction

   function automatic void emit(kind_type kind, logic [7:0] addr, logic [7:0] data,
                                logic [31:0] fa);
      player_output_type r;
      r.kind          = kind;
      r.reg_addr      = addr;
      r.reg_data      = data;
      r.fetch_address = fa;
      r.play_offset   = 24'(offset_q);
      r.last          = 1'b0;
      player_output_q.push_back(r);
      outputs_this_request++;
   endfunction

   // fetch reports the offset before it advances
   function automatic void emit_fetch();
      emit(KIND_FETCH, 8'h00, 8'h00, player_cfg.stream_base + 32'(offset_q));
      offset_q = offset_q + 1'b1;
   endfunction

   function automatic void emit_silence();
      for (int i = 0; i < SILENCE_LEN; i++)
         emit(KIND_WRITE, SILENCE_REG_OFFSET[i], SILENCE_REG_VALUE[i], 32'h0);
   endfunction

   // one request through the player, returns the number of results it causes
   function automatic int advance_player(req_code_type rt, logic lp, logic [7:0] b);
      player_output_type tail;
      int                k;
      outputs_this_request = 0;
      case (rt)
         REQ_PLAY: begin
            clear_player();
            emit_silence();
            playing_q = 1'b1;
            looping_q = lp;
         end
         REQ_STOP: begin
            emit_silence();
            playing_q = 1'b0;
            phase_q   = PH_IDLE;
            emit(KIND_STOPPED, 8'h00, 8'h00, 32'h0);
         end
         REQ_TICK: begin
            // a tick in the middle of a frame is dropped
            if (!playing_q) begin
               emit(KIND_STOPPED, 8'h00, 8'h00, 32'h0);
            end else if (phase_q == PH_IDLE) begin
               phase_q = PH_CMD;
               emit_fetch();
            end
         end
         default: begin
            if (playing_q && phase_q != PH_IDLE) begin
               case (phase_q)
                  PH_CMD: begin
                     // opcode priority: write, then wait, then end
                     if (b == player_cfg.write_opcode) begin
                        phase_q = PH_ADDR;
                        emit_fetch();
                     end else if (b == player_cfg.wait_opcode) begin
                        phase_q = PH_IDLE;
                        emit(KIND_FRAME, 8'h00, 8'h00, 32'h0);
                     end else if (b == player_cfg.end_opcode) begin
                        if (looping_q) begin
                           phase_q       = PH_LOOP0;
                           loop_offset_q = 32'h0;
                           emit_fetch();
                        end else begin
                           emit_silence();
                           playing_q = 1'b0;
                           phase_q   = PH_IDLE;
                           emit(KIND_STOPPED, 8'h00, 8'h00, 32'h0);
                        end
                     end else begin
                        phase_q = PH_IDLE;
                        emit(KIND_UNKNOWN, 8'h00, 8'h00, 32'h0);
                     end
                  end
                  PH_ADDR: begin
                     held_addr_q = b;
                     phase_q     = PH_DATA;
                     emit_fetch();
                  end
                  PH_DATA: begin
                     emit(KIND_WRITE, held_addr_q, b, 32'h0);
                     phase_q = PH_CMD;
                     emit_fetch();
                  end
                  default: begin
                     // loop offset, little-endian
                     k = int'(phase_q) - int'(PH_LOOP0);
                     loop_offset_q = loop_offset_q | (32'(b) << (8 * k));
                     if (k == 3) begin
                        offset_q = loop_offset_q[OFFSET_BITS-1:0];
                        phase_q  = PH_IDLE;
                        emit(KIND_FRAME, 8'h00, 8'h00, 32'h0);
                     end else begin
                        phase_q = phase_type'(phase_q + 3'd1);
                        emit_fetch();
                     end
                  end
               endcase
            end
         end
      endcase
      if (outputs_this_request > 0) begin
         tail      = player_output_q.pop_back();
         tail.last = 1'b1;
         player_output_q.push_back(tail);
      end
      return outputs_this_request;
   endfunction

   // ---------------------------------------------------------------- result side

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // random back-pressure, each result compared with the oldest prediction
   initial begin : result_sink
      player_output_type want;
      int                stall;
      wait (reset == 1'b0);
      forever begin
         stall = sink_stalls_on ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (player_output_q.size() == 0) begin
            $error("result with nothing pending: kind %0d", rsp_kind);
            mismatch_count++;
         end else begin
            want = player_output_q.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("reg_addr", want.reg_addr, rsp_reg_addr);
            check_field("reg_data", want.reg_data, rsp_reg_data);
            check_field("fetch_address", want.fetch_address, rsp_fetch_address);
            check_field("play_offset", want.play_offset, rsp_play_offset);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- request side

   // one request; valid stays up after acceptance so back-to-back requests need
   // no extra edge
   task automatic send_request(req_code_type rt, logic lp, logic [7:0] b);
      int gap;
      gap = src_gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= rt;
      req_loop_enable <= lp;
      req_stream_byte <= b;
      do @(posedge clock); while (!req_ready);
      void'(advance_player(rt, lp, b));
   endtask

   // drop valid, drain every result, then let any dropped request finish
   task automatic settle_player();
      req_valid <= 1'b0;
      while (player_output_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all four registers, upper data bits of the opcode writes are junk
   task automatic apply_settings(logic [31:0] base, logic [7:0] wr_op,
                                 logic [7:0] wait_op, logic [7:0] end_op);
      settle_player();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_STREAM_BASE;
      csr_wdata        <= base;
      @(posedge clock);
      csr_index        <= CSR_WRITE_OPCODE;
      csr_wdata        <= {24'($urandom), wr_op};
      @(posedge clock);
      csr_index        <= CSR_WAIT_OPCODE;
      csr_wdata        <= {24'($urandom), wait_op};
      @(posedge clock);
      csr_index        <= CSR_END_OPCODE;
      csr_wdata        <= {24'($urandom), end_op};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      player_cfg.stream_base  = base;
      player_cfg.write_opcode = wr_op;
      player_cfg.wait_opcode  = wait_op;
      player_cfg.end_opcode   = end_op;
   endtask

   // mostly well-formed commands, some random bytes
   function automatic logic [7:0] pick_command_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return player_cfg.write_opcode;
      if (r < 75) return player_cfg.wait_opcode;
      if (r < 85) return player_cfg.end_opcode;
      return 8'($urandom_range(0, 255));
   endfunction

   // random stream steered by the model state; ignored requests are not counted
   task automatic run_random_stream(int target);
      int           counted;
      int           roll;
      req_code_type rt;
      logic         lp;
      logic [7:0]   b;
      counted = 0;
      while (counted < target) begin
         roll = $urandom_range(0, 99);
         lp   = 1'($urandom_range(0, 1));
         b    = 8'($urandom_range(0, 255));
         if (!playing_q)
            rt = roll < 70 ? REQ_PLAY : roll < 80 ? REQ_TICK : roll < 90 ? REQ_BYTE : REQ_STOP;
         else if (phase_q == PH_IDLE)
            rt = roll < 80 ? REQ_TICK : roll < 86 ? REQ_BYTE : roll < 93 ? REQ_STOP : REQ_PLAY;
         else
            rt = roll < 90 ? REQ_BYTE : roll < 94 ? REQ_TICK : roll < 97 ? REQ_STOP : REQ_PLAY;
         if (rt == REQ_BYTE && playing_q && phase_q == PH_CMD)
            b = pick_command_byte();
         send_request(rt, lp, b);
         if (outputs_this_request > 0) counted++;
      end
   endtask

   // ---------------------------------------------------------------- tests

   // requests while nothing plays, at reset settings
   task automatic test_stopped_requests();
      send_request(REQ_TICK, 1'b1, 8'hff);
      send_request(REQ_BYTE, 1'b0, 8'h00);
      send_request(REQ_STOP, 1'b1, 8'h5a);
   endtask

   // write, wait, unknown and end without loop
   task automatic test_frame_commands();
      send_request(REQ_PLAY, 1'b0, 8'h00);
      send_request(REQ_BYTE, 1'b1, 8'h33);
      send_request(REQ_TICK, 1'b0, 8'h00);
      send_request(REQ_TICK, 1'b1, 8'hff);
      send_request(REQ_BYTE, 1'b0, player_cfg.write_opcode);
      send_request(REQ_BYTE, 1'b0, 8'hff);
      send_request(REQ_BYTE, 1'b0, 8'h00);
      send_request(REQ_BYTE, 1'b0, player_cfg.wait_opcode);
      send_request(REQ_TICK, 1'b0, 8'h00);
      send_request(REQ_BYTE, 1'b0, 8'haa);
      send_request(REQ_TICK, 1'b0, 8'h00);
      send_request(REQ_BYTE, 1'b0, player_cfg.end_opcode);
   endtask

   // loop jump to the top offset, offset wrap, stop mid-frame
   task automatic test_loop_and_wrap();
      send_request(REQ_PLAY, 1'b1, 8'h00);
      send_request(REQ_TICK, 1'b0, 8'h00);
      send_request(REQ_BYTE, 1'b0, player_cfg.end_opcode);
      repeat (4) send_request(REQ_BYTE, 1'b0, 8'hff);
      send_request(REQ_TICK, 1'b0, 8'h00);
      send_request(REQ_BYTE, 1'b0, player_cfg.write_opcode);
      send_request(REQ_STOP, 1'b0, 8'h00);
   endtask

   // opcode priority when codes coincide
   task automatic test_equal_opcodes();
      apply_settings(32'h8000_0000, 8'h5a, 8'h5a, 8'h5a);
      send_request(REQ_PLAY, 1'b1, 8'h00);
      send_request(REQ_TICK, 1'b0, 8'h00);
      send_request(REQ_BYTE, 1'b0, 8'h5a);
      send_request(REQ_BYTE, 1'b0, 8'h5a);
      send_request(REQ_BYTE, 1'b0, 8'h01);
      apply_settings(32'h8000_0000, 8'h11, 8'h22, 8'h22);
      send_request(REQ_BYTE, 1'b0, 8'h22);
      apply_settings(32'h8000_0000, 8'h11, 8'h33, 8'h11);
      send_request(REQ_TICK, 1'b0, 8'h00);
      send_request(REQ_BYTE, 1'b0, 8'h11);
   endtask

   task automatic test_random_phase(logic [31:0] base, logic [7:0] wr_op,
                                    logic [7:0] wait_op, logic [7:0] end_op,
                                    int items, bit with_idling);
      apply_settings(base, wr_op, wait_op, end_op);
      src_gaps_on    = with_idling;
      sink_stalls_on = with_idling;
      run_random_stream(items);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      player_cfg = '{stream_base:  STREAM_BASE_RESET,
                     write_opcode: WRITE_OPCODE_RESET,
                     wait_opcode:  WAIT_OPCODE_RESET,
                     end_opcode:   END_OPCODE_RESET};
      clear_player();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_stopped_requests();
      test_frame_commands();
      test_loop_and_wrap();
      test_equal_opcodes();
      test_random_phase(32'hffff_ffff, 8'h00, 8'hff, 8'h80, 30, 1'b1);
      test_random_phase($urandom, 8'($urandom), 8'($urandom), 8'($urandom), 30, 1'b1);
      test_random_phase(32'h0000_0000, WRITE_OPCODE_RESET, WAIT_OPCODE_RESET,
                        END_OPCODE_RESET, 30, 1'b0);
      test_random_phase(32'hffff_ff00, 8'hff, 8'h00, 8'h7f, 30, 1'b1);

      settle_player();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/srcp_pkg.sv
rtl/srcp_parser.sv
rtl/srcp_emitter.sv
rtl/sound_register_command_player.sv
tb/tb.sv
